### rtl/hrt_pkg.sv
// shared types, constants and tables for the haversine range tracker
`timescale 1ns / 1ps
package hrt_pkg;

  localparam int ANGLE_FRACTION_BITS = 30;
  localparam int F = ANGLE_FRACTION_BITS;
  localparam int ITER_W = $clog2(F + 1);
  localparam int ROM_IDX_W = $clog2(F);
  localparam int VAL_W = F + 6;
  localparam int MAG_W = 32;
  localparam int PROD_W = 2 * MAG_W;
  localparam int SQ_W = 2 * F + 2;
  localparam int SR_W = F + 5;
  localparam int SQQ_W = F + 1;
  localparam int LAT_W = 28;
  localparam int LON_W = 29;
  localparam int RAD_W = 13;
  localparam int K_W = 24;
  localparam int DIST_W = 25;
  localparam int ANG_W = 32;
  localparam int CFG_DATA_W = 29;
  localparam int CFG_IDX_W = 2;
  localparam int IN_DATA_W = 64;
  localparam int OUT_DATA_W = 80;

  localparam logic [CFG_IDX_W-1:0] REG_REF_LAT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REF_LON = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd2;

  localparam logic signed [LAT_W-1:0] RESET_REF_LAT = 28'sd44820783;
  localparam logic signed [LON_W-1:0] RESET_REF_LON = -29'sd501887;
  localparam logic [RAD_W-1:0] RESET_RADIUS = 13'd6371;

  localparam logic signed [ANG_W-1:0] TURN = 32'sd720000000;
  localparam logic signed [ANG_W-1:0] HALF_TURN = 32'sd360000000;
  localparam logic signed [ANG_W-1:0] QUARTER_TURN = 32'sd180000000;

  localparam longint unsigned PI_Q60 = 64'h3243F6A8885A308D;
  localparam longint unsigned GAIN_Q60 = 64'd700114967507363114;
  localparam longint unsigned RAD_Q56 = (PI_Q60 >> 4) / 64'd360000000;
  localparam longint unsigned GAIN_F = (GAIN_Q60 + (64'd1 << (59 - F))) >> (60 - F);
  localparam longint unsigned ONE_F = 64'd1 << F;
  localparam logic [PROD_W-1:0] HALF_F = PROD_W'(64'd1 << (F - 1));
  localparam logic [PROD_W-1:0] HALF_Z = PROD_W'(64'd1 << (55 - F));
  localparam logic [PROD_W-1:0] DIST_LIMIT = PROD_W'(64'd33554431);
  localparam logic [K_W-1:0] METRES_PER_KM_X2 = 24'd2000;

  typedef logic signed [VAL_W-1:0] val_t;
  typedef val_t atan_rom_t [F];

  // long division by shift and subtract, used only while building the table
  function automatic longint unsigned shift_divide(longint unsigned num,
                                                   longint unsigned den);
    longint unsigned q;
    longint unsigned r;
    q = 0;
    r = 0;
    for (int bi = 63; bi >= 0; bi--) begin
      r = (r << 1) | ((num >> bi) & 64'd1);
      if (r >= den) begin
        r = r - den;
        q = q | (64'd1 << bi);
      end
    end
    return q;
  endfunction

  function automatic atan_rom_t build_atan_rom();
    atan_rom_t t;
    longint v;
    longint term;
    int e;
    int k;
    for (int i = 0; i < F; i++) begin
      v = 0;
      if (i == 0) begin
        v = longint'(PI_Q60 >> 2);
      end else begin
        e = i;
        k = 0;
        while (e <= 60) begin
          term = longint'(shift_divide(64'd1 << (60 - e), 64'(2 * k + 1)));
          v = ((k & 1) != 0) ? v - term : v + term;
          e = e + 2 * i;
          k = k + 1;
        end
      end
      t[i] = VAL_W'((v + (longint'(1) << (59 - F))) >>> (60 - F));
    end
    return t;
  endfunction

  localparam atan_rom_t ATAN_ROM = build_atan_rom();

  typedef enum logic [3:0] {
    DP_NOP,
    DP_CAPTURE,
    DP_ANGLE,
    DP_ZMUL,
    DP_ROT_INIT,
    DP_ROT,
    DP_SC_STORE,
    DP_MUL,
    DP_MUL_STORE,
    DP_A,
    DP_SQRT_INIT,
    DP_SQRT,
    DP_SQRT_STORE,
    DP_VEC_INIT,
    DP_VEC,
    DP_DIST
  } dp_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ANGLE,
    S_ZMUL,
    S_ZINIT,
    S_ROT,
    S_SC_STORE,
    S_MUL,
    S_MUL_STORE,
    S_A,
    S_SQRT_INIT,
    S_SQRT,
    S_SQRT_STORE,
    S_VEC_INIT,
    S_VEC,
    S_DIST_MUL,
    S_DIST
  } ctrl_state_t;

  localparam logic [2:0] SEL_DIST = 3'd4;

  typedef struct packed {
    dp_op_t op;
    logic [2:0] sel;
  } dp_cmd_t;

  typedef struct packed {
    logic rot_last;
    logic sqrt_last;
    logic out_busy;
  } dp_status_t;

endpackage

### rtl/hrt_ctrl.sv
// sequencer that steps the datapath through one position report
`timescale 1ns / 1ps
module hrt_ctrl
  import hrt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  ctrl_state_t state, state_next;
  logic [2:0] sel, sel_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sel <= '0;
    end else begin
      state <= state_next;
      sel <= sel_next;
    end
  end

  always_comb begin
    state_next = state;
    sel_next = sel;
    case (state)
      S_IDLE: begin
        if (in_tvalid) begin
          state_next = S_ANGLE;
          sel_next = '0;
        end
      end
      S_ANGLE: state_next = S_ZMUL;
      S_ZMUL: state_next = S_ZINIT;
      S_ZINIT: state_next = S_ROT;
      S_ROT: begin
        if (status.rot_last) state_next = S_SC_STORE;
      end
      S_SC_STORE: begin
        if (sel == 3'd3) begin
          sel_next = '0;
          state_next = S_MUL;
        end else begin
          sel_next = sel + 3'd1;
          state_next = S_ANGLE;
        end
      end
      S_MUL: state_next = S_MUL_STORE;
      S_MUL_STORE: begin
        if (sel == 3'd3) begin
          sel_next = '0;
          state_next = S_A;
        end else begin
          sel_next = sel + 3'd1;
          state_next = S_MUL;
        end
      end
      S_A: state_next = S_SQRT_INIT;
      S_SQRT_INIT: state_next = S_SQRT;
      S_SQRT: begin
        if (status.sqrt_last) state_next = S_SQRT_STORE;
      end
      S_SQRT_STORE: begin
        if (sel == 3'd1) begin
          sel_next = '0;
          state_next = S_VEC_INIT;
        end else begin
          sel_next = 3'd1;
          state_next = S_SQRT_INIT;
        end
      end
      S_VEC_INIT: state_next = S_VEC;
      S_VEC: begin
        if (status.rot_last) state_next = S_DIST_MUL;
      end
      S_DIST_MUL: state_next = S_DIST;
      S_DIST: begin
        if (!status.out_busy) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    cmd.op = DP_NOP;
    cmd.sel = sel;
    case (state)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) cmd.op = DP_CAPTURE;
      end
      S_ANGLE: cmd.op = DP_ANGLE;
      S_ZMUL: cmd.op = DP_ZMUL;
      S_ZINIT: cmd.op = DP_ROT_INIT;
      S_ROT: cmd.op = DP_ROT;
      S_SC_STORE: cmd.op = DP_SC_STORE;
      S_MUL: cmd.op = DP_MUL;
      S_MUL_STORE: cmd.op = DP_MUL_STORE;
      S_A: cmd.op = DP_A;
      S_SQRT_INIT: cmd.op = DP_SQRT_INIT;
      S_SQRT: cmd.op = DP_SQRT;
      S_SQRT_STORE: cmd.op = DP_SQRT_STORE;
      S_VEC_INIT: cmd.op = DP_VEC_INIT;
      S_VEC: cmd.op = DP_VEC;
      S_DIST_MUL: begin
        cmd.op = DP_MUL;
        cmd.sel = SEL_DIST;
      end
      S_DIST: begin
        if (!status.out_busy) cmd.op = DP_DIST;
      end
      default: cmd.op = DP_NOP;
    endcase
  end

endmodule

### rtl/hrt_datapath.sv
// cordic, multiplier, square root and range tracking registers
`timescale 1ns / 1ps
module hrt_datapath
  import hrt_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  dp_cmd_t                     cmd,
  output dp_status_t                  status,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data,
  input  logic signed [LAT_W-1:0]     in_lat,
  input  logic signed [LON_W-1:0]     in_lon,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [DIST_W-1:0]           out_cur,
  output logic [DIST_W-1:0]           out_min,
  output logic [DIST_W-1:0]           out_max
);

  logic signed [LAT_W-1:0] ref_lat;
  logic signed [LON_W-1:0] ref_lon;
  logic [RAD_W-1:0] radius;
  logic signed [LAT_W-1:0] lat;
  logic signed [LON_W-1:0] lon;
  logic [K_W-1:0] k_scale;
  logic [DIST_W-1:0] least, greatest;

  logic [MAG_W-1:0] ang_mag;
  logic ang_neg, flip;
  logic [PROD_W-1:0] prod;
  logic mul_neg;
  val_t cx, cy, cz;
  logic [ITER_W-1:0] iter;
  val_t s1, s2, c1, c2, m1, m2, m3, m4, a_val;
  logic [SQ_W-1:0] sq_w;
  logic [SR_W-1:0] sq_r;
  logic [SQQ_W-1:0] sq_q;

  // angle reduction
  logic signed [ANG_W-1:0] h, h1, rr;
  logic rr_flip;
  always_comb begin
    case (cmd.sel)
      3'd0: h = ANG_W'(ref_lat) - ANG_W'(lat);
      3'd1: h = ANG_W'(ref_lon) - ANG_W'(lon);
      3'd2: h = ANG_W'(lat) <<< 1;
      default: h = ANG_W'(ref_lat) <<< 1;
    endcase
    if (h >= HALF_TURN) h1 = h - TURN;
    else if (h < -HALF_TURN) h1 = h + TURN;
    else h1 = h;
    rr_flip = 1'b0;
    if (h1 > QUARTER_TURN) begin
      rr = HALF_TURN - h1;
      rr_flip = 1'b1;
    end else if (h1 < -QUARTER_TURN) begin
      rr = -HALF_TURN - h1;
      rr_flip = 1'b1;
    end else begin
      rr = h1;
    end
  end

  function automatic logic [MAG_W-1:0] mag_of(val_t v);
    val_t n;
    n = v[VAL_W-1] ? -v : v;
    return n[MAG_W-1:0];
  endfunction

  // shared multiplier operands
  logic [MAG_W-1:0] mul_a, mul_b;
  logic mul_sign;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    mul_sign = 1'b0;
    if (cmd.op == DP_ZMUL) begin
      mul_a = ang_mag;
      mul_b = MAG_W'(RAD_Q56);
    end else begin
      case (cmd.sel)
        3'd0: begin
          mul_a = mag_of(s1);
          mul_b = mag_of(s1);
        end
        3'd1: begin
          mul_a = mag_of(c1);
          mul_b = mag_of(c2);
          mul_sign = c1[VAL_W-1] ^ c2[VAL_W-1];
        end
        3'd2: begin
          mul_a = mag_of(s2);
          mul_b = mag_of(s2);
        end
        3'd3: begin
          mul_a = mag_of(m2);
          mul_b = mag_of(m3);
          mul_sign = m2[VAL_W-1] ^ m3[VAL_W-1];
        end
        default: begin
          mul_a = cz[VAL_W-1] ? '0 : cz[MAG_W-1:0];
          mul_b = MAG_W'(k_scale);
        end
      endcase
    end
  end

  logic [PROD_W-1:0] rnd;
  val_t mres;
  logic [DIST_W-1:0] dist_sat;
  logic [PROD_W-1:0] zrnd;
  assign rnd = (prod + HALF_F) >> F;
  assign mres = mul_neg ? -VAL_W'(rnd) : VAL_W'(rnd);
  assign dist_sat = (rnd > DIST_LIMIT) ? DIST_LIMIT[DIST_W-1:0] : rnd[DIST_W-1:0];
  assign zrnd = (prod + HALF_Z) >> (56 - F);

  // cordic step
  val_t sh_x, sh_y, rom;
  logic y_pos;
  assign sh_x = cx >>> iter;
  assign sh_y = cy >>> iter;
  assign rom = ATAN_ROM[iter[ROM_IDX_W-1:0]];
  assign y_pos = !cy[VAL_W-1] && (cy != '0);

  // clamp of a
  logic signed [VAL_W:0] a_sum;
  val_t a_clamp;
  assign a_sum = (VAL_W + 1)'(m1) + (VAL_W + 1)'(m4);
  always_comb begin
    if (a_sum < 0) a_clamp = '0;
    else if (a_sum > (VAL_W + 1)'(ONE_F)) a_clamp = VAL_W'(ONE_F);
    else a_clamp = a_sum[VAL_W-1:0];
  end

  // square root step
  val_t sq_src;
  logic [SR_W-1:0] sr_sh, sr_trial;
  assign sq_src = (cmd.sel == 3'd0) ? VAL_W'(ONE_F) - a_val : a_val;
  assign sr_sh = {sq_r[SR_W-3:0], sq_w[SQ_W-1 -: 2]};
  assign sr_trial = SR_W'({sq_q, 2'b01});

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_lat <= RESET_REF_LAT;
      ref_lon <= RESET_REF_LON;
      radius <= RESET_RADIUS;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_REF_LAT: ref_lat <= cfg_data[LAT_W-1:0];
        REG_REF_LON: ref_lon <= cfg_data[LON_W-1:0];
        REG_RADIUS: radius <= cfg_data[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      least <= '0;
      greatest <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.op == DP_DIST) begin
        out_valid <= 1'b1;
        out_cur <= dist_sat;
        if (greatest != '0) begin
          if (dist_sat > greatest) begin
            greatest <= dist_sat;
            out_max <= dist_sat;
          end else begin
            out_max <= greatest;
          end
          if (dist_sat < least) begin
            least <= dist_sat;
            out_min <= dist_sat;
          end else begin
            out_min <= least;
          end
        end else begin
          greatest <= dist_sat;
          least <= dist_sat;
          out_max <= dist_sat;
          out_min <= dist_sat;
        end
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_CAPTURE: begin
        lat <= in_lat;
        lon <= in_lon;
        k_scale <= K_W'(radius) * METRES_PER_KM_X2;
      end
      DP_ANGLE: begin
        ang_mag <= rr[ANG_W-1] ? MAG_W'(-rr) : MAG_W'(rr);
        ang_neg <= rr[ANG_W-1];
        flip <= rr_flip;
      end
      DP_ZMUL, DP_MUL: begin
        prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
        mul_neg <= mul_sign;
      end
      DP_ROT_INIT: begin
        cz <= ang_neg ? -VAL_W'(zrnd) : VAL_W'(zrnd);
        cx <= VAL_W'(GAIN_F);
        cy <= '0;
        iter <= '0;
      end
      DP_ROT: begin
        if (!cz[VAL_W-1]) begin
          cx <= cx - sh_y;
          cy <= cy + sh_x;
          cz <= cz - rom;
        end else begin
          cx <= cx + sh_y;
          cy <= cy - sh_x;
          cz <= cz + rom;
        end
        iter <= iter + ITER_W'(1);
      end
      DP_SC_STORE: begin
        case (cmd.sel)
          3'd0: s1 <= cy;
          3'd1: s2 <= cy;
          3'd2: c1 <= flip ? -cx : cx;
          default: c2 <= flip ? -cx : cx;
        endcase
      end
      DP_MUL_STORE: begin
        case (cmd.sel)
          3'd0: m1 <= mres;
          3'd1: m2 <= mres;
          3'd2: m3 <= mres;
          default: m4 <= mres;
        endcase
      end
      DP_A: a_val <= a_clamp;
      DP_SQRT_INIT: begin
        sq_w <= {1'b0, sq_src[F:0], F'(0)};
        sq_r <= '0;
        sq_q <= '0;
        iter <= '0;
      end
      DP_SQRT: begin
        sq_w <= {sq_w[SQ_W-3:0], 2'b00};
        if (sr_sh >= sr_trial) begin
          sq_r <= sr_sh - sr_trial;
          sq_q <= {sq_q[SQQ_W-2:0], 1'b1};
        end else begin
          sq_r <= sr_sh;
          sq_q <= {sq_q[SQQ_W-2:0], 1'b0};
        end
        iter <= iter + ITER_W'(1);
      end
      DP_SQRT_STORE: begin
        if (cmd.sel == 3'd0) cx <= VAL_W'(sq_q);
        else cy <= VAL_W'(sq_q);
      end
      DP_VEC_INIT: begin
        cz <= '0;
        iter <= '0;
      end
      DP_VEC: begin
        if (y_pos) begin
          cx <= cx + sh_y;
          cy <= cy - sh_x;
          cz <= cz + rom;
        end else begin
          cx <= cx - sh_y;
          cy <= cy + sh_x;
          cz <= cz - rom;
        end
        iter <= iter + ITER_W'(1);
      end
      default: ;
    endcase
  end

  assign status = '{
    rot_last: (iter == ITER_W'(F - 1)),
    sqrt_last: (iter == ITER_W'(F)),
    out_busy: (out_valid && !out_ready)
  };

endmodule

### rtl/haversine_range_tracker.sv
// top level of the haversine range tracker
// one report at a time, accepted only in idle; the shared cordic unit runs
//   four rotations of 30 steps, two 31-step square roots and one 30-step vectoring
// reset: reference point and radius return to defaults, minimum and maximum clear
`timescale 1ns / 1ps
module haversine_range_tracker
  import hrt_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_DATA_W-1:0]   s_axis_tdata,   // latitude_udeg, longitude_udeg, zero pad
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_DATA_W-1:0]  m_axis_tdata,   // current, minimum, maximum distance, zero pad
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  dp_cmd_t cmd;
  dp_status_t status;
  logic [DIST_W-1:0] cur, dmin, dmax;

  hrt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_tvalid (s_axis_tvalid),
    .in_tready (s_axis_tready),
    .status    (status),
    .cmd       (cmd)
  );

  hrt_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_lat    (s_axis_tdata[LAT_W-1:0]),
    .in_lon    (s_axis_tdata[LAT_W+LON_W-1:LAT_W]),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_cur   (cur),
    .out_min   (dmin),
    .out_max   (dmax)
  );

  assign m_axis_tdata = {(OUT_DATA_W - 3 * DIST_W)'(0), dmax, dmin, cur};

endmodule
